[src/bmra_pkg.sv]
// package: shared constants, opcode and state types for the broadcast mailbox
package bmra_pkg;

  localparam int unsigned BUF_BYTES    = 4096;
  localparam int unsigned READER_SLOTS = 8;

  localparam int unsigned POS_W   = $clog2(BUF_BYTES + 1);
  localparam int unsigned ADDR_W  = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int unsigned SLOT_W  = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
  localparam int unsigned ROUND_W = 64;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned LEN_W   = 13;

  localparam logic [CNT_W-1:0] CFG_RESET = 4'd1;

  typedef enum logic [3:0] {
    OP_INIT    = 4'd0,
    OP_POLL    = 4'd1,
    OP_BEGIN   = 4'd2,
    OP_WBYTE   = 4'd3,
    OP_PUBLISH = 4'd4,
    OP_TAKE    = 4'd5,
    OP_RBYTE   = 4'd6,
    OP_ACK     = 4'd7,
    OP_DEPART  = 4'd8,
    OP_NEVER   = 4'd9
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
    logic respond;
  } dp_cmd_t;

endpackage

[src/bmra_ram.sv]
// generic single write port ram with registered read
module bmra_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bmra_ctrl.sv]
// controller: sequences capture, execute and respond for each item
module bmra_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output bmra_pkg::dp_cmd_t cmd_o
);

  bmra_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmra_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bmra_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = bmra_pkg::ST_EXEC;
        end
      end
      bmra_pkg::ST_EXEC: state_d = bmra_pkg::ST_RESP;
      bmra_pkg::ST_RESP: state_d = bmra_pkg::ST_IDLE;
      default:           state_d = bmra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      bmra_pkg::ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      bmra_pkg::ST_EXEC: cmd_o.execute = 1'b1;
      bmra_pkg::ST_RESP: cmd_o.respond = 1'b1;
      default:           busy_o = 1'b1;
    endcase
  end

  a_resp_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmra_pkg::ST_RESP) |=> !busy_o)
    else $error("controller did not return to idle after a result");

endmodule

[src/bmra_dp.sv]
// datapath: mailbox state, reader slots, byte store and result registers
module bmra_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bmra_pkg::dp_cmd_t                 cmd_i,
  input  logic                              cfg_we_i,
  input  logic [bmra_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic [3:0]                        opcode_i,
  input  logic                              role_i,
  input  logic [2:0]                        reader_id_i,
  input  logic [31:0]                       count_i,
  input  logic [7:0]                        data_byte_i,
  input  logic [31:0]                       bytes_read_i,
  input  logic                              session_active_i,
  output logic                              done_o,
  output logic [7:0]                        read_byte_o,
  output logic [bmra_pkg::LEN_W-1:0]        length_o,
  output logic                              ready_res_o,
  output logic                              over_o,
  output logic                              short_ack_o
);

  localparam int unsigned POS_W   = bmra_pkg::POS_W;
  localparam int unsigned CNT_W   = bmra_pkg::CNT_W;
  localparam int unsigned ROUND_W = bmra_pkg::ROUND_W;
  localparam int unsigned SLOT_W  = bmra_pkg::SLOT_W;
  localparam int unsigned SLOTS   = bmra_pkg::READER_SLOTS;
  localparam logic [POS_W-1:0] BUF_POS = POS_W'(bmra_pkg::BUF_BYTES);

  // captured item
  bmra_pkg::opcode_e op_q;
  logic              role_q;
  logic [2:0]        id_q;
  logic [31:0]       count_q;
  logic [7:0]        data_q;
  logic [31:0]       nread_q;
  logic              active_q;

  // mailbox state
  logic [CNT_W-1:0]   cfg_q;
  logic [POS_W-1:0]   round_len_q, round_len_d;
  logic [ROUND_W-1:0] round_q, round_d;
  logic [CNT_W-1:0]   ap_q, ap_d;
  logic [CNT_W-1:0]   live_q, live_d;
  logic               end_q, end_d;
  logic               over_q, over_d;
  logic [POS_W-1:0]   wpos_q, wpos_d;
  logic               az_q, az_d;
  logic [POS_W-1:0]   hwm_q, hwm_d;

  logic [ROUND_W-1:0] last_round_q [SLOTS];
  logic               owes_q       [SLOTS];
  logic [POS_W-1:0]   rpos_q       [SLOTS];

  // results
  logic [POS_W-1:0] len_q, len_d;
  logic             ready_q, ready_d;
  logic             short_q, short_d;
  logic             rb_hit_q, rb_hit_d;

  // slot access
  logic [SLOT_W-1:0]  idx;
  logic               slot_ok;
  logic [ROUND_W-1:0] cur_last;
  logic               cur_owes;
  logic [POS_W-1:0]   cur_pos;
  logic               slot_we;
  logic               clear_all;
  logic [ROUND_W-1:0] slot_last_d;
  logic               slot_owes_d;
  logic [POS_W-1:0]   slot_pos_d;

  logic             drop_owes;
  logic [CNT_W-1:0] ap_t;
  logic [CNT_W-1:0] lr_t;

  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= bmra_pkg::opcode_e'(opcode_i);
      role_q   <= role_i;
      id_q     <= reader_id_i;
      count_q  <= count_i;
      data_q   <= data_byte_i;
      nread_q  <= bytes_read_i;
      active_q <= session_active_i;
    end
  end

  assign idx      = SLOT_W'(id_q);
  assign slot_ok  = 32'(id_q) < SLOTS;
  assign cur_last = last_round_q[idx];
  assign cur_owes = owes_q[idx];
  assign cur_pos  = rpos_q[idx];

  // reader departure count adjustment
  always_comb begin
    drop_owes = slot_ok && (cur_owes || (cur_last < round_q));
    ap_t = ap_q;
    if (drop_owes && ap_t != '0) begin
      ap_t = ap_t - CNT_W'(1);
    end
    lr_t = live_q;
    if (lr_t != '0) begin
      lr_t = lr_t - CNT_W'(1);
    end
    if (ap_t > lr_t) begin
      ap_t = lr_t;
    end
  end

  always_comb begin
    round_len_d = round_len_q;
    round_d     = round_q;
    ap_d        = ap_q;
    live_d      = live_q;
    end_d       = end_q;
    over_d      = over_q;
    wpos_d      = wpos_q;
    az_d        = az_q;
    hwm_d       = hwm_q;
    len_d       = '0;
    ready_d     = 1'b0;
    short_d     = 1'b0;
    rb_hit_d    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    slot_we     = 1'b0;
    clear_all   = 1'b0;
    slot_last_d = cur_last;
    slot_owes_d = cur_owes;
    slot_pos_d  = cur_pos;
    unique case (op_q)
      bmra_pkg::OP_INIT: begin
        clear_all   = 1'b1;
        round_len_d = '0;
        round_d     = '0;
        ap_d        = '0;
        live_d      = cfg_q;
        end_d       = 1'b0;
        over_d      = 1'b0;
        wpos_d      = '0;
        az_d        = 1'b1;
      end
      bmra_pkg::OP_POLL: begin
        if (!role_q) begin
          if (end_q && ap_q == '0) begin
            over_d = 1'b1;
          end
          ready_d = over_q || (ap_q == '0);
        end else if (slot_ok) begin
          ready_d = over_q || (round_q > cur_last);
        end
      end
      bmra_pkg::OP_BEGIN: begin
        az_d   = (count_q == '0);
        wpos_d = '0;
        if (count_q > 32'(bmra_pkg::BUF_BYTES)) begin
          round_len_d = BUF_POS;
        end else begin
          round_len_d = POS_W'(count_q);
        end
      end
      bmra_pkg::OP_WBYTE: begin
        if (wpos_q < BUF_POS) begin
          ram_we = 1'b1;
          wpos_d = wpos_q + POS_W'(1);
          if (wpos_q >= hwm_q) begin
            hwm_d = wpos_q + POS_W'(1);
          end
        end
      end
      bmra_pkg::OP_PUBLISH: begin
        len_d = round_len_q;
        if (az_q) begin
          end_d = 1'b1;
        end
        round_d = round_q + ROUND_W'(1);
        ap_d    = live_q;
        wpos_d  = '0;
        az_d    = 1'b1;
      end
      bmra_pkg::OP_TAKE: begin
        if (slot_ok) begin
          slot_we     = 1'b1;
          slot_last_d = round_q;
          slot_owes_d = 1'b1;
          slot_pos_d  = '0;
          len_d       = round_len_q;
        end
      end
      bmra_pkg::OP_RBYTE: begin
        if (slot_ok) begin
          ram_re   = 1'b1;
          rb_hit_d = (cur_pos < round_len_q) && (cur_pos < BUF_POS) && (cur_pos < hwm_q);
          slot_we  = 1'b1;
          if (cur_pos < BUF_POS) begin
            slot_pos_d = cur_pos + POS_W'(1);
          end
        end
      end
      bmra_pkg::OP_ACK: begin
        if (slot_ok) begin
          short_d     = nread_q < 32'(round_len_q);
          slot_we     = 1'b1;
          slot_pos_d  = '0;
          slot_owes_d = 1'b0;
          if (cur_owes && ap_q != '0) begin
            ap_d = ap_q - CNT_W'(1);
          end
        end
      end
      bmra_pkg::OP_DEPART: begin
        if (active_q) begin
          if (role_q) begin
            if (slot_ok) begin
              slot_we     = 1'b1;
              slot_owes_d = 1'b0;
            end
            ap_d   = ap_t;
            live_d = lr_t;
          end else begin
            over_d = 1'b1;
          end
        end
      end
      bmra_pkg::OP_NEVER: begin
        if (role_q) begin
          ap_d   = (ap_q > lr_t) ? lr_t : ap_q;
          live_d = lr_t;
        end else begin
          over_d = 1'b1;
        end
      end
      default: begin
        ready_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= bmra_pkg::CFG_RESET;
      round_len_q <= '0;
      round_q     <= '0;
      ap_q        <= '0;
      live_q      <= bmra_pkg::CFG_RESET;
      end_q       <= 1'b0;
      over_q      <= 1'b0;
      wpos_q      <= '0;
      az_q        <= 1'b1;
      hwm_q       <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        last_round_q[i] <= '0;
        owes_q[i]       <= 1'b0;
        rpos_q[i]       <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.execute) begin
        round_len_q <= round_len_d;
        round_q     <= round_d;
        ap_q        <= ap_d;
        live_q      <= live_d;
        end_q       <= end_d;
        over_q      <= over_d;
        wpos_q      <= wpos_d;
        az_q        <= az_d;
        hwm_q       <= hwm_d;
        if (clear_all) begin
          for (int i = 0; i < SLOTS; i++) begin
            last_round_q[i] <= '0;
            owes_q[i]       <= 1'b0;
            rpos_q[i]       <= '0;
          end
        end else if (slot_we) begin
          last_round_q[idx] <= slot_last_d;
          owes_q[idx]       <= slot_owes_d;
          rpos_q[idx]       <= slot_pos_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      len_q    <= len_d;
      ready_q  <= ready_d;
      short_q  <= short_d;
      rb_hit_q <= rb_hit_d;
    end
  end

  bmra_ram #(
    .Width (8),
    .Depth (bmra_pkg::BUF_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.execute && ram_we),
    .waddr_i (wpos_q[bmra_pkg::ADDR_W-1:0]),
    .wdata_i (data_q),
    .re_i    (cmd_i.execute && ram_re),
    .raddr_i (cur_pos[bmra_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign done_o       = cmd_i.respond;
  assign read_byte_o  = rb_hit_q ? ram_rdata : 8'd0;
  assign length_o     = bmra_pkg::LEN_W'(len_q);
  assign ready_res_o  = ready_q;
  assign over_o       = over_q;
  assign short_ack_o  = short_q;

  a_acks_le_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ap_q <= live_q)
    else $error("pending acks exceed live readers");

  a_wpos_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= hwm_q)
    else $error("writer position beyond byte store fill mark");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hwm_q <= BUF_POS)
    else $error("byte store fill mark beyond buffer size");

endmodule

[src/broadcast_mailbox_round_ack_unit.sv]
// top level: broadcast mailbox with round acknowledgement
// usage:
//   an item is taken when start_i is high and busy_o is low; the item's fields
//   are sampled at that edge. each item gives one result: done_o is high for
//   exactly one cycle while read_byte_o, length_o, ready_res_o, over_o and
//   short_ack_o carry it. the receiver cannot stall the result.
//   the item is captured at the accepting edge, the execute state updates the
//   session and the result registers, and done_o is raised in the respond state.
//   busy_o stays high until the done_o cycle ends, so no new item is taken before
//   the result is given; the byte store's registered read sets the result stage.
//   cfg_we_i writes readers_at_start from cfg_wdata_i; write it only while
//   busy_o is low.
//   reset sets readers_at_start to 1 and clears the session state and the fill
//   mark, but not the byte store: entries beyond the written fill mark read as
//   zero, so no clearing pass is needed and items are taken right after reset.
//   the init opcode restores the session but keeps the stored bytes.
module broadcast_mailbox_round_ack_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       cfg_we_i,
  input  logic [bmra_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic [3:0]                 opcode_i,
  input  logic                       role_i,
  input  logic [2:0]                 reader_id_i,
  input  logic [31:0]                count_i,
  input  logic [7:0]                 data_byte_i,
  input  logic [31:0]                bytes_read_i,
  input  logic                       session_active_i,
  output logic                       done_o,
  output logic [7:0]                 read_byte_o,
  output logic [bmra_pkg::LEN_W-1:0] length_o,
  output logic                       ready_res_o,
  output logic                       over_o,
  output logic                       short_ack_o
);

  bmra_pkg::dp_cmd_t cmd;

  bmra_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  bmra_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .opcode_i         (opcode_i),
    .role_i           (role_i),
    .reader_id_i      (reader_id_i),
    .count_i          (count_i),
    .data_byte_i      (data_byte_i),
    .bytes_read_i     (bytes_read_i),
    .session_active_i (session_active_i),
    .done_o           (done_o),
    .read_byte_o      (read_byte_o),
    .length_o         (length_o),
    .ready_res_o      (ready_res_o),
    .over_o           (over_o),
    .short_ack_o      (short_ack_o)
  );

endmodule

[test/tb.sv]
// testbench for broadcast_mailbox_round_ack_unit: directed and random mailbox traffic
`timescale 1ns / 1ps

module tb;

  localparam int unsigned BUF_BYTES    = bmra_pkg::BUF_BYTES;
  localparam int unsigned READER_SLOTS = bmra_pkg::READER_SLOTS;
  localparam int unsigned LEN_W        = bmra_pkg::LEN_W;
  localparam int unsigned CNT_W        = bmra_pkg::CNT_W;

  localparam logic ROLE_WR = 1'b0;
  localparam logic ROLE_RD = 1'b1;
  localparam logic [3:0] OP_SPARE_TOP = 4'd15;
  localparam logic [LEN_W-1:0] BUF_FULL = LEN_W'(BUF_BYTES);
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_QUIET = 100;

  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CFG,
    ACT_DRAIN
  } act_e;

  typedef struct {
    act_e        act;
    logic [3:0]  op;
    logic        role;
    logic [2:0]  id;
    logic [31:0] count;
    logic [7:0]  data;
    logic [31:0] nread;
    logic        active;
    logic [3:0]  cfg;
  } mbox_cmd_t;

  typedef struct packed {
    logic [7:0]       read_byte;
    logic [LEN_W-1:0] length;
    logic             ready;
    logic             over;
    logic             short_ack;
  } mbox_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;
  logic [3:0]  opcode_i = '0;
  logic        role_i = 1'b0;
  logic [2:0]  reader_id_i = '0;
  logic [31:0] count_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic [31:0] bytes_read_i = '0;
  logic        session_active_i = 1'b0;
  logic        done_o;
  logic [7:0]  read_byte_o;
  logic [LEN_W-1:0] length_o;
  logic        ready_res_o;
  logic        over_o;
  logic        short_ack_o;

  broadcast_mailbox_round_ack_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .opcode_i         (opcode_i),
    .role_i           (role_i),
    .reader_id_i      (reader_id_i),
    .count_i          (count_i),
    .data_byte_i      (data_byte_i),
    .bytes_read_i     (bytes_read_i),
    .session_active_i (session_active_i),
    .done_o           (done_o),
    .read_byte_o      (read_byte_o),
    .length_o         (length_o),
    .ready_res_o      (ready_res_o),
    .over_o           (over_o),
    .short_ack_o      (short_ack_o)
  );

  // mailbox shadow state
  logic [7:0]       mb_bytes [BUF_BYTES];
  logic [LEN_W-1:0] mb_round_len;
  logic [63:0]      mb_round;
  logic [CNT_W-1:0] mb_acks;
  logic [CNT_W-1:0] mb_live;
  logic             mb_end_seen;
  logic             mb_over;
  logic [LEN_W-1:0] mb_wr_pos;
  logic             mb_zero_count;
  logic [63:0]      mb_last_round [READER_SLOTS];
  logic             mb_owes [READER_SLOTS];
  logic [LEN_W-1:0] mb_rd_pos [READER_SLOTS];
  logic [CNT_W-1:0] mb_readers_cfg;

  mbox_cmd_t pending_cmds [$];
  mbox_res_t due_results [$];
  mbox_cmd_t on_bus;
  int        queued = 0;
  int        sent = 0;
  int        quiet_from = 0;
  int        gap_left = 0;
  int        in_flight = 0;
  int        stall_cycles = 0;
  int        mismatches = 0;
  int        fill_cfg = 1;
  int        fill_live = 1;
  logic      stim_done = 1'b0;

  function automatic void restart_session();
    mb_round_len  = '0;
    mb_round      = '0;
    mb_acks       = '0;
    mb_live       = mb_readers_cfg;
    mb_end_seen   = 1'b0;
    mb_over       = 1'b0;
    mb_wr_pos     = '0;
    mb_zero_count = 1'b1;
    for (int i = 0; i < READER_SLOTS; i++) begin
      mb_last_round[i] = '0;
      mb_owes[i]       = 1'b0;
      mb_rd_pos[i]     = '0;
    end
  endfunction

  function automatic logic [LEN_W-1:0] step_pos(input logic [LEN_W-1:0] p);
    return (p < BUF_FULL) ? p + 1'b1 : BUF_FULL;
  endfunction

  function automatic void release_reader(input logic owes);
    if (owes && mb_acks > 0) mb_acks = mb_acks - 1'b1;
    if (mb_live > 0) mb_live = mb_live - 1'b1;
    if (mb_acks > mb_live) mb_acks = mb_live;
  endfunction

  function automatic mbox_res_t apply_mailbox_op(input mbox_cmd_t c);
    mbox_res_t        r;
    logic             slot_ok;
    logic             owes;
    logic [LEN_W-1:0] p;
    r = '0;
    slot_ok = (c.id < READER_SLOTS);
    owes = 1'b0;
    case (c.op)
      bmra_pkg::OP_INIT: restart_session();
      bmra_pkg::OP_POLL: begin
        if (c.role == ROLE_WR) begin
          if (mb_end_seen && mb_acks == 0) mb_over = 1'b1;
          r.ready = mb_over || (mb_acks == 0);
        end else if (slot_ok) begin
          r.ready = mb_over || (mb_round > mb_last_round[c.id]);
        end
      end
      bmra_pkg::OP_BEGIN: begin
        mb_zero_count = (c.count == 0);
        mb_wr_pos = '0;
        mb_round_len = (c.count > BUF_BYTES) ? BUF_FULL : c.count[LEN_W-1:0];
      end
      bmra_pkg::OP_WBYTE: begin
        if (mb_wr_pos < BUF_FULL) mb_bytes[mb_wr_pos] = c.data;
        mb_wr_pos = step_pos(mb_wr_pos);
      end
      bmra_pkg::OP_PUBLISH: begin
        r.length = mb_round_len;
        if (mb_zero_count) mb_end_seen = 1'b1;
        mb_round = mb_round + 1'b1;
        mb_acks = mb_live;
        mb_wr_pos = '0;
        mb_zero_count = 1'b1;
      end
      bmra_pkg::OP_TAKE: begin
        if (slot_ok) begin
          mb_last_round[c.id] = mb_round;
          mb_owes[c.id] = 1'b1;
          mb_rd_pos[c.id] = '0;
          r.length = mb_round_len;
        end
      end
      bmra_pkg::OP_RBYTE: begin
        if (slot_ok) begin
          p = mb_rd_pos[c.id];
          if (p < mb_round_len && p < BUF_FULL) r.read_byte = mb_bytes[p];
          mb_rd_pos[c.id] = step_pos(p);
        end
      end
      bmra_pkg::OP_ACK: begin
        if (slot_ok) begin
          r.short_ack = (c.nread < mb_round_len);
          mb_rd_pos[c.id] = '0;
          if (mb_owes[c.id]) begin
            mb_owes[c.id] = 1'b0;
            if (mb_acks > 0) mb_acks = mb_acks - 1'b1;
          end
        end
      end
      bmra_pkg::OP_DEPART: begin
        if (c.active) begin
          if (c.role == ROLE_RD) begin
            if (slot_ok) begin
              owes = mb_owes[c.id] || (mb_last_round[c.id] < mb_round);
              mb_owes[c.id] = 1'b0;
            end
            release_reader(owes);
          end else begin
            mb_over = 1'b1;
          end
        end
      end
      bmra_pkg::OP_NEVER: begin
        if (c.role == ROLE_RD) release_reader(1'b0);
        else mb_over = 1'b1;
      end
      default: ;
    endcase
    r.over = mb_over;
    return r;
  endfunction

  task automatic add_op(input logic [3:0] op, input logic role = ROLE_WR,
                        input logic [2:0] id = '0, input logic [31:0] count = '0,
                        input logic [7:0] data = '0, input logic [31:0] nread = '0,
                        input logic active = 1'b0);
    mbox_cmd_t c;
    c.act = ACT_ITEM;
    c.op = op;
    c.role = role;
    c.id = id;
    c.count = count;
    c.data = data;
    c.nread = nread;
    c.active = active;
    c.cfg = '0;
    pending_cmds.push_back(c);
    queued++;
  endtask

  task automatic add_marker(input act_e act, input logic [3:0] cfg);
    mbox_cmd_t c;
    c = '{act: act, op: bmra_pkg::OP_INIT, role: ROLE_WR, id: '0, count: '0, data: '0,
          nread: '0, active: 1'b0, cfg: cfg};
    pending_cmds.push_back(c);
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) begin
      add_op(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
             $urandom, 8'($urandom_range(0, 255)), $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  // one writer round followed by each live reader taking and reading it, then acking it or departing
  task automatic add_round();
    int          len;
    int          nw;
    int          k;
    int          base;
    logic [2:0]  id;
    logic [31:0] cnt;
    logic [31:0] nr;
    logic        last;
    last = ($urandom_range(0, 9) == 0);
    len = last ? 0 : $urandom_range(0, 12);
    if (!last && $urandom_range(0, 7) == 0) len = $urandom_range(13, 60);
    cnt = len;
    if (!last && $urandom_range(0, 15) == 0) cnt = $urandom;
    if ($urandom_range(0, 1)) add_op(bmra_pkg::OP_POLL, ROLE_WR);
    if (!last || $urandom_range(0, 1)) begin
      add_op(bmra_pkg::OP_BEGIN, 1'($urandom_range(0, 1)), 0, cnt);
    end
    nw = len + $urandom_range(0, 2);
    if ($urandom_range(0, 5) == 0) nw = $urandom_range(0, len);
    for (int i = 0; i < nw; i++) begin
      add_op(bmra_pkg::OP_WBYTE, 1'($urandom_range(0, 1)), 0, 0, 8'($urandom_range(0, 255)));
    end
    add_op(bmra_pkg::OP_PUBLISH, 1'($urandom_range(0, 1)));
    base = $urandom_range(0, 7);
    for (int r = 0; r < fill_live; r++) begin
      id = 3'(base + r);
      if ($urandom_range(0, 2) == 0) add_op(bmra_pkg::OP_POLL, ROLE_RD, id);
      add_op(bmra_pkg::OP_TAKE, 1'($urandom_range(0, 1)), id);
      k = len + $urandom_range(0, 2);
      if ($urandom_range(0, 4) == 0) k = $urandom_range(0, len);
      for (int i = 0; i < k; i++) add_op(bmra_pkg::OP_RBYTE, 1'($urandom_range(0, 1)), id);
      if ($urandom_range(0, 11) == 0) begin
        add_op(bmra_pkg::OP_DEPART, ROLE_RD, id, 0, 0, 0, 1'($urandom_range(0, 1)));
      end else begin
        case ($urandom_range(0, 3))
          0: nr = k;
          1: nr = len;
          2: nr = $urandom;
          default: nr = $urandom_range(0, len);
        endcase
        add_op(bmra_pkg::OP_ACK, 1'($urandom_range(0, 1)), id, 0, 0, nr);
      end
    end
    add_op(bmra_pkg::OP_POLL, ROLE_WR);
    if (last) begin
      add_op(bmra_pkg::OP_INIT);
      fill_live = fill_cfg;
    end
  endtask

  task automatic add_phase(input int cfg, input int n);
    int target;
    add_marker(ACT_CFG, 4'(cfg));
    add_op(bmra_pkg::OP_INIT);
    fill_cfg = cfg;
    fill_live = cfg;
    target = queued + n;
    while (queued < target) begin
      add_round();
      if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 4));
      if ($urandom_range(0, 5) == 0) add_marker(ACT_DRAIN, '0);
    end
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    logic accepted;
    logic go;
    logic we;
    if (rst_ni) begin
      accepted = start_i && !busy_o;
      go = start_i;
      we = 1'b0;
      in_flight = in_flight + int'(accepted) - int'(done_o);
      if (accepted) begin
        due_results.push_back(apply_mailbox_op(on_bus));
        sent++;
        go = 1'b0;
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() == 0) begin
          stim_done = 1'b1;
        end else if (pending_cmds[0].act == ACT_ITEM) begin
          if (sent < quiet_from && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 8);
          end else begin
            on_bus = pending_cmds.pop_front();
            opcode_i <= on_bus.op;
            role_i <= on_bus.role;
            reader_id_i <= on_bus.id;
            count_i <= on_bus.count;
            data_byte_i <= on_bus.data;
            bytes_read_i <= on_bus.nread;
            session_active_i <= on_bus.active;
            go = 1'b1;
          end
        end else if (in_flight == 0) begin
          if (pending_cmds[0].act == ACT_CFG) begin
            we = 1'b1;
            cfg_wdata_i <= pending_cmds[0].cfg;
            mb_readers_cfg = pending_cmds[0].cfg;
          end
          void'(pending_cmds.pop_front());
        end
      end
      start_i <= go;
      cfg_we_i <= we;
    end
  end

  task automatic compare_field(input string what, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    mbox_res_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with no item outstanding", $time);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        compare_field("read_byte", LEN_W'(want.read_byte), LEN_W'(read_byte_o));
        compare_field("length", want.length, length_o);
        compare_field("ready_res", LEN_W'(want.ready), LEN_W'(ready_res_o));
        compare_field("over", LEN_W'(want.over), LEN_W'(over_o));
        compare_field("short_ack", LEN_W'(want.short_ack), LEN_W'(short_ack_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("broadcast_mailbox_round_ack_unit regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < BUF_BYTES; i++) mb_bytes[i] = '0;
    mb_readers_cfg = bmra_pkg::CFG_RESET;
    restart_session();

    // directed
    add_op(bmra_pkg::OP_POLL, ROLE_WR);
    add_op(bmra_pkg::OP_POLL, ROLE_RD, 0);
    add_op(bmra_pkg::OP_TAKE, ROLE_RD, 0);
    add_op(bmra_pkg::OP_ACK, ROLE_RD, 0);
    add_op(bmra_pkg::OP_BEGIN, ROLE_WR, 0, 32'hFFFF_FFFF);
    add_op(bmra_pkg::OP_WBYTE, ROLE_WR, 0, 0, 8'hFF);
    add_op(bmra_pkg::OP_WBYTE, ROLE_RD, 0, 0, 8'h00);
    add_op(bmra_pkg::OP_WBYTE, ROLE_WR, 0, 0, 8'hA5);
    add_op(bmra_pkg::OP_PUBLISH);
    add_op(bmra_pkg::OP_TAKE, ROLE_WR, 7);
    for (int i = 0; i < 3; i++) add_op(bmra_pkg::OP_RBYTE, ROLE_RD, 7);
    add_op(bmra_pkg::OP_ACK, ROLE_RD, 7, 0, 0, 3);
    add_op(bmra_pkg::OP_ACK, ROLE_RD, 3, 0, 0, 32'hFFFF_FFFF);
    add_op(bmra_pkg::OP_POLL, ROLE_RD, 7);
    add_op(bmra_pkg::OP_POLL, ROLE_RD, 2);
    add_op(bmra_pkg::OP_BEGIN, ROLE_RD, 0, 2);
    add_op(bmra_pkg::OP_WBYTE, ROLE_WR, 0, 0, 8'h5A);
    add_op(bmra_pkg::OP_WBYTE, ROLE_WR, 0, 0, 8'h3C);
    add_op(bmra_pkg::OP_PUBLISH, ROLE_RD);
    add_op(bmra_pkg::OP_POLL, ROLE_WR);
    add_op(bmra_pkg::OP_DEPART, ROLE_RD, 4, 0, 0, 0, 1'b0);
    add_op(bmra_pkg::OP_DEPART, ROLE_RD, 4, 0, 0, 0, 1'b1);
    add_op(bmra_pkg::OP_NEVER, ROLE_RD);
    add_op(OP_SPARE_TOP);
    add_op(bmra_pkg::OP_PUBLISH);
    add_op(bmra_pkg::OP_POLL, ROLE_WR);
    add_op(bmra_pkg::OP_INIT);
    add_op(bmra_pkg::OP_NEVER, ROLE_WR);
    add_op(bmra_pkg::OP_DEPART, ROLE_WR, 0, 0, 0, 0, 1'b1);
    add_op(bmra_pkg::OP_INIT);
    add_marker(ACT_DRAIN, '0);

    // random phases over several reader counts
    add_phase(8, 80);
    add_phase(0, 80);
    add_phase(1, 60);
    add_phase($urandom_range(2, 7), 80);
    add_phase(8, 80);
    add_phase($urandom_range(0, 8), 80);
    quiet_from = queued - TAIL_QUIET;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (!(stim_done && in_flight == 0));
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("broadcast_mailbox_round_ack_unit regression: pass");
    end else begin
      $display("broadcast_mailbox_round_ack_unit regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/bmra_pkg.sv
src/bmra_ram.sv
src/bmra_ctrl.sv
src/bmra_dp.sv
src/broadcast_mailbox_round_ack_unit.sv
test/tb.sv
